### src/btnd_pkg.sv
// Shared types, status codes and character constants for the byte-text notation decoder.
`timescale 1ns / 1ps

package btnd_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOKEN      = 3'd1;
	localparam logic [2:0] ST_HEX        = 3'd2;
	localparam logic [2:0] ST_BITS       = 3'd3;
	localparam logic [2:0] ST_GAP        = 3'd4;
	localparam logic [2:0] ST_ORDER      = 3'd5;
	localparam logic [2:0] ST_OVERLAP    = 3'd6;
	localparam logic [2:0] ST_INCOMPLETE = 3'd7;

	// Character codes the scanner recognizes.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_X      = 8'h78;

	// Outcome of settling one bit token against the open bit group.
	typedef struct packed {
		logic [2:0] status;
		logic       emit;
		logic [7:0] value;
		logic [7:0] owned;
		logic [7:0] acc;
		logic [2:0] next_pos;
	} grp_res_t;

	// Returns {valid, digit} for an ASCII hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

### src/btnd_group.sv
// Settles a finished bit token against the open bit group of the current byte.
`timescale 1ns / 1ps

module btnd_group
	import btnd_pkg::*;
(
	input  logic [7:0] tok_mask,
	input  logic [7:0] tok_value,
	input  logic [7:0] owned,
	input  logic [7:0] acc,
	input  logic [2:0] next_pos,
	output grp_res_t   res
);

	logic [2:0] first;
	logic [3:0] last_end;
	logic       seen;
	logic [7:0] span;
	logic [7:0] merged_owned;
	logic [7:0] merged_acc;

	// Position i sits at bit 7-i, so the scan runs from the MSB down.
	always_comb begin
		first    = 3'd0;
		last_end = 4'd0;
		seen     = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (tok_mask[7 - i]) begin
				if (!seen) begin
					first = 3'(i);
				end
				seen     = 1'b1;
				last_end = 4'(i + 1);
			end
		end
		for (int i = 0; i < 8; i++) begin
			span[7 - i] = (4'(i) >= {1'b0, first}) && (4'(i) < last_end);
		end
	end

	assign merged_owned = owned | tok_mask;
	assign merged_acc   = acc | (tok_value & tok_mask);

	always_comb begin
		res.status   = ST_OK;
		res.emit     = 1'b0;
		res.value    = merged_acc;
		res.owned    = owned;
		res.acc      = acc;
		res.next_pos = next_pos;
		if (tok_mask != 8'd0) begin
			if ((span & ~tok_mask) != 8'd0) begin
				res.status = ST_GAP;
			end else if ((owned & tok_mask) != 8'd0) begin
				res.status = ST_OVERLAP;
			end else if (first != next_pos) begin
				res.status = ST_ORDER;
			end else if (last_end == 4'd8) begin
				// The group reached the last bit: the byte is complete.
				res.emit     = 1'b1;
				res.owned    = 8'd0;
				res.acc      = 8'd0;
				res.next_pos = 3'd0;
			end else begin
				res.owned    = merged_owned;
				res.acc      = merged_acc;
				res.next_pos = last_end[2:0];
			end
		end
	end

endmodule

### src/byte_text_notation_decoder.sv
// Top level of the byte-text notation decoder: input register, scanner and result register.
`timescale 1ns / 1ps

// A character is captured in the input register and scanned from there; its result, if any,
// is loaded into the output register that drives the master side.
// Throughput: one transaction per cycle while the output register is free; a result held
// back by m_tready stalls the scanner. Every character takes a single scanner step.
// Reset: arst_n clears the scanner to its idle state with line and column at 1 and drops
// both valid flags. The end marker restarts the scanner to the same state.
module byte_text_notation_decoder
	import btnd_pkg::*;
#(
	parameter int LINE_BITS = 16,
	parameter int COL_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: one character or the end marker per transaction.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] kind (1 = end of text)
	// Master side: one result per transaction.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data_byte, [10:8] status, [26:11] err_line,
	                               // [42:27] err_col, [47:43] zero
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast    // done_res, set on the result of the end marker
);

	// Scanner modes.
	localparam logic [3:0] M_IDLE      = 4'd0;
	localparam logic [3:0] M_SLASH     = 4'd1;
	localparam logic [3:0] M_COMMENT   = 4'd2;
	localparam logic [3:0] M_BSLASH    = 4'd3;
	localparam logic [3:0] M_HEX_A     = 4'd4;
	localparam logic [3:0] M_HEX_B     = 4'd5;
	localparam logic [3:0] M_HEX_B_BAD = 4'd6;
	localparam logic [3:0] M_BITS      = 4'd7;
	localparam logic [3:0] M_TAIL      = 4'd8;
	localparam logic [3:0] M_FAILED    = 4'd9;

	// Input register.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] char_s1;

	// Scanner state.
	logic [3:0]           mode_q;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  col_q;
	logic [LINE_BITS-1:0] tok_line_q;
	logic [COL_BITS-1:0]  tok_col_q;
	logic [3:0]           hex_high_q;
	logic [15:0]          pat_q;
	logic [3:0]           bcnt_q;
	logic [7:0]           acc_q;
	logic [7:0]           owned_q;
	logic [2:0]           next_q;
	logic [2:0]           fail_q;

	// Next-state values.
	logic [3:0]           mode_d;
	logic [LINE_BITS-1:0] line_d;
	logic [COL_BITS-1:0]  col_d;
	logic [LINE_BITS-1:0] tok_line_d;
	logic [COL_BITS-1:0]  tok_col_d;
	logic [3:0]           hex_high_d;
	logic [15:0]          pat_d;
	logic [3:0]           bcnt_d;
	logic [7:0]           acc_d;
	logic [7:0]           owned_d;
	logic [2:0]           next_d;
	logic [2:0]           fail_d;

	// Result of the current step.
	logic                 res_valid;
	logic                 res_emit;
	logic [7:0]           res_value;
	logic                 res_done;
	logic [2:0]           res_status;
	logic [LINE_BITS-1:0] res_line;
	logic [COL_BITS-1:0]  res_col;
	logic [31:0]          res_line_ext;
	logic [31:0]          res_col_ext;

	// Handshake and helpers.
	logic                 out_free;
	logic                 advance;
	logic [LINE_BITS-1:0] line_inc;
	logic [COL_BITS-1:0]  col_inc;
	logic [4:0]           hex_dig;
	logic [7:0]           bit_mask;
	logic                 do_idle;
	logic [2:0]           st;
	grp_res_t             grp;

	// Output register.
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	// The scanner steps when the input register holds an item and the output register
	// can take a result; a new transaction enters whenever the input register drains.
	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Line and column stop at their maximum instead of wrapping.
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
	assign col_inc  = (col_q == '1) ? col_q : col_q + COL_BITS'(1);
	assign hex_dig  = hex_value(char_s1);
	assign bit_mask = 8'h80 >> bcnt_q[2:0];

	btnd_group u_group (
		.tok_mask (pat_q[15:8]),
		.tok_value(pat_q[7:0]),
		.owned    (owned_q),
		.acc      (acc_q),
		.next_pos (next_q),
		.res      (grp)
	);

	always_comb begin
		mode_d     = mode_q;
		line_d     = line_q;
		col_d      = col_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		hex_high_d = hex_high_q;
		pat_d      = pat_q;
		bcnt_d     = bcnt_q;
		acc_d      = acc_q;
		owned_d    = owned_q;
		next_d     = next_q;
		fail_d     = fail_q;
		res_valid  = 1'b0;
		res_emit   = 1'b0;
		res_value  = grp.value;
		res_done   = 1'b0;
		res_line   = tok_line_q;
		res_col    = tok_col_q;
		do_idle    = 1'b0;
		st         = ST_OK;

		if (kind_s1) begin
			// End of text: report the outcome, then restart from the reset state.
			unique case (mode_q)
				M_FAILED: st = fail_q;
				M_SLASH, M_BSLASH, M_HEX_A, M_HEX_B, M_HEX_B_BAD: st = ST_TOKEN;
				M_BITS: st = ST_BITS;
				M_TAIL: begin
					st       = grp.status;
					res_emit = grp.emit;
				end
				default: st = ST_OK;
			endcase
			// An open group is judged after the pending bit token has been settled.
			if (st == ST_OK && ((mode_q == M_TAIL) ? grp.next_pos : next_q) != 3'd0) begin
				st       = ST_INCOMPLETE;
				res_line = line_q;
				res_col  = col_q;
			end
			res_valid  = 1'b1;
			res_done   = 1'b1;
			mode_d     = M_IDLE;
			line_d     = LINE_BITS'(1);
			col_d      = COL_BITS'(1);
			tok_line_d = LINE_BITS'(1);
			tok_col_d  = COL_BITS'(1);
			hex_high_d = 4'd0;
			pat_d      = 16'd0;
			bcnt_d     = 4'd0;
			acc_d      = 8'd0;
			owned_d    = 8'd0;
			next_d     = 3'd0;
			fail_d     = ST_OK;
		end else begin
			unique case (mode_q)
				M_FAILED: begin
					// Everything up to the end marker is dropped.
				end
				M_COMMENT: begin
					if (char_s1 == CH_LF) begin
						mode_d  = M_IDLE;
						do_idle = 1'b1;
					end else begin
						col_d = col_inc;
					end
				end
				M_SLASH: begin
					if (char_s1 == CH_SLASH) begin
						col_d  = col_inc;
						mode_d = M_COMMENT;
					end else begin
						st = ST_TOKEN;
					end
				end
				M_BSLASH: begin
					if (char_s1 == CH_X) begin
						col_d  = col_inc;
						mode_d = M_HEX_A;
					end else if (char_s1 == CH_B) begin
						col_d  = col_inc;
						bcnt_d = 4'd0;
						pat_d  = 16'd0;
						mode_d = M_BITS;
					end else begin
						st = ST_TOKEN;
					end
				end
				M_HEX_A: begin
					col_d = col_inc;
					if (hex_dig[4]) begin
						hex_high_d = hex_dig[3:0];
						mode_d     = M_HEX_B;
					end else begin
						mode_d = M_HEX_B_BAD;
					end
				end
				M_HEX_B, M_HEX_B_BAD: begin
					// The second digit is consumed even when the first one was bad.
					col_d = col_inc;
					if (!hex_dig[4] || mode_q == M_HEX_B_BAD) begin
						st = ST_HEX;
					end else if (next_q != 3'd0) begin
						st = ST_INCOMPLETE;
					end else begin
						res_emit  = 1'b1;
						res_value = {hex_high_q, hex_dig[3:0]};
						mode_d    = M_IDLE;
					end
				end
				M_BITS: begin
					if (char_s1 == CH_APOS && bcnt_q == 4'd4) begin
						col_d = col_inc;
					end else if (char_s1 == CH_ZERO || char_s1 == CH_ONE ||
					             char_s1 == CH_UNDER) begin
						if (char_s1 != CH_UNDER) begin
							pat_d[15:8] = pat_q[15:8] | bit_mask;
						end
						if (char_s1 == CH_ONE) begin
							pat_d[7:0] = pat_q[7:0] | bit_mask;
						end
						bcnt_d = bcnt_q + 4'd1;
						col_d  = col_inc;
						if (bcnt_q == 4'd7) begin
							mode_d = M_TAIL;
						end
					end else begin
						st = ST_BITS;
					end
				end
				M_TAIL: begin
					// The character after a bit token settles it, then is scanned itself.
					if (char_s1 == CH_APOS) begin
						st = ST_BITS;
					end else if (grp.status != ST_OK) begin
						st = grp.status;
					end else begin
						res_emit = grp.emit;
						acc_d    = grp.acc;
						owned_d  = grp.owned;
						next_d   = grp.next_pos;
						mode_d   = M_IDLE;
						do_idle  = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// Scanning between tokens: blanks, line feeds and token starts.
			if (do_idle) begin
				if (char_s1 == CH_SPACE || char_s1 == CH_TAB || char_s1 == CH_CR) begin
					col_d = col_inc;
				end else if (char_s1 == CH_LF) begin
					line_d = line_inc;
					col_d  = COL_BITS'(1);
				end else begin
					tok_line_d = line_q;
					tok_col_d  = col_q;
					if (char_s1 == CH_SLASH) begin
						col_d  = col_inc;
						mode_d = M_SLASH;
					end else if (char_s1 == CH_BSLASH) begin
						col_d  = col_inc;
						mode_d = M_BSLASH;
					end else begin
						st = ST_TOKEN;
					end
				end
			end

			// The first error freezes the scanner until the end marker.
			if (st != ST_OK) begin
				mode_d = M_FAILED;
				fail_d = st;
			end
			res_valid = res_emit || (st != ST_OK);
			res_line  = tok_line_d;
			res_col   = tok_col_d;
		end
		res_status = st;
	end

	assign res_line_ext = 32'(res_line);
	assign res_col_ext  = 32'(res_col);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			line_q     <= LINE_BITS'(1);
			col_q      <= COL_BITS'(1);
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COL_BITS'(1);
			hex_high_q <= 4'd0;
			pat_q      <= 16'd0;
			bcnt_q     <= 4'd0;
			acc_q      <= 8'd0;
			owned_q    <= 8'd0;
			next_q     <= 3'd0;
			fail_q     <= ST_OK;
		end else if (advance) begin
			mode_q     <= mode_d;
			line_q     <= line_d;
			col_q      <= col_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			hex_high_q <= hex_high_d;
			pat_q      <= pat_d;
			bcnt_q     <= bcnt_d;
			acc_q      <= acc_d;
			owned_q    <= owned_d;
			next_q     <= next_d;
			fail_q     <= fail_d;
		end
	end

	// Output register: loaded when a step yields a result, drained by m_tready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			m_tuser_q <= res_emit;
			m_tlast_q <= res_done;
			m_tdata_q <= {5'd0,
			              (res_status != ST_OK) ? res_col_ext[15:0] : 16'd0,
			              (res_status != ST_OK) ? res_line_ext[15:0] : 16'd0,
			              res_status,
			              res_emit ? res_value : 8'd0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The owned positions always form a run from the MSB that ends at the next position.
	a_owned_run: assert property (@(posedge clk) disable iff (!arst_n)
		owned_q == ~(8'hFF >> next_q))
		else $error("owned positions do not match the next position");

	// The end marker always leaves the scanner restarted.
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 |=> mode_q == M_IDLE && next_q == 3'd0 && line_q == LINE_BITS'(1))
		else $error("scanner not restarted after the end marker");

	// A failed scanner yields nothing for characters.
	a_failed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !kind_s1 && mode_q == M_FAILED |-> !res_valid)
		else $error("result produced while failed");

	// A byte in a character result carries either no error or a bad-token status.
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q && !m_tlast_q |->
			m_tdata_q[10:8] == ST_OK || m_tdata_q[10:8] == ST_TOKEN)
		else $error("byte carried with an unexpected status");

	// A byte comes only from the second hex digit or from the item that settles a bit token.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_emit |->
			mode_q == M_TAIL || mode_q == M_HEX_B)
		else $error("byte emitted outside a token end");

endmodule

### verif/byte_text_notation_decoder_tb.sv
// Testbench for the byte-text notation decoder: streamed text against a predicting scoreboard.
`timescale 1ns / 1ps

module byte_text_notation_decoder_tb;
	import btnd_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int CALM_TAIL      = 250;
	localparam int LONG_RUN       = 24;
	// The pipeline, the result-side stalls and the input gaps are all short next to this limit:
	// a healthy run always has a transaction on one side well within it.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 6;

	// Characters beyond the ones the package names.
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_F = 8'h66;
	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_UC_F = 8'h46;
	localparam logic [7:0] CH_Q    = 8'h71;

	typedef enum logic [3:0] {
		SCAN_IDLE,
		SCAN_SLASH,
		SCAN_COMMENT,
		SCAN_BSLASH,
		SCAN_HEX_HI,
		SCAN_HEX_LO,
		SCAN_HEX_LO_BAD,
		SCAN_BITS,
		SCAN_TAIL,
		SCAN_FAILED
	} scan_mode_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        done;
		logic [2:0]  status;
		logic [15:0] err_line;
		logic [15:0] err_col;
	} decode_outcome_t;

	// Tracks the decoder's scan state and keeps the outcomes still owed by the block.
	class notation_scoreboard;
		scan_mode_t      mode;
		logic [15:0]     line_no, col_no, mark_line, mark_col;
		logic [3:0]      hex_hi;
		logic [7:0]      tok_mask, tok_ones;
		int              bit_cnt;
		logic [7:0]      acc, owned;
		logic [2:0]      next_pos;
		logic [2:0]      fail_st;
		decode_outcome_t awaited_outcomes[$];
		int              mismatch_count;

		function new();
			mismatch_count = 0;
			restart();
		endfunction

		function void restart();
			mode      = SCAN_IDLE;
			line_no   = 16'd1;
			col_no    = 16'd1;
			mark_line = 16'd1;
			mark_col  = 16'd1;
			hex_hi    = 4'd0;
			tok_mask  = 8'h00;
			tok_ones  = 8'h00;
			bit_cnt   = 0;
			acc       = 8'h00;
			owned     = 8'h00;
			next_pos  = 3'd0;
			fail_st   = ST_OK;
		endfunction

		function logic [15:0] sat_up(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic nibble_of(logic [7:0] c, output logic [3:0] nib);
			nib = 4'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				nib = 4'(c - CH_ZERO);
				return 1'b1;
			end
			if (c >= CH_LC_A && c <= CH_LC_F) begin
				nib = 4'(c - CH_LC_A + 8'd10);
				return 1'b1;
			end
			if (c >= CH_UC_A && c <= CH_UC_F) begin
				nib = 4'(c - CH_UC_A + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function decode_outcome_t make_outcome(logic emit, logic [7:0] val, logic done,
				logic [2:0] st, logic [15:0] ln, logic [15:0] cl);
			decode_outcome_t r;
			r.byte_valid = emit;
			r.data_byte  = emit ? val : 8'h00;
			r.done       = done;
			r.status     = st;
			r.err_line   = (st != ST_OK) ? ln : 16'd0;
			r.err_col    = (st != ST_OK) ? cl : 16'd0;
			return r;
		endfunction

		// Merge the finished bit token into the open group; a run that reaches the last
		// position closes the byte.
		function logic [2:0] settle_group(output logic emit, output logic [7:0] val);
			int first, stop, i;
			emit = 1'b0;
			val  = 8'h00;
			if (tok_mask == 8'h00)
				return ST_OK;
			first = 8;
			stop  = 0;
			for (i = 0; i < 8; i++) begin
				if (tok_mask[7 - i]) begin
					if (first == 8)
						first = i;
					stop = i + 1;
				end
			end
			for (i = first; i < stop; i++) begin
				if (!tok_mask[7 - i])
					return ST_GAP;
			end
			if ((owned & tok_mask) != 8'h00)
				return ST_OVERLAP;
			if (first != int'(next_pos))
				return ST_ORDER;
			owned    = owned | tok_mask;
			acc      = acc | (tok_ones & tok_mask);
			next_pos = 3'(stop);
			if (stop == 8) begin
				emit     = 1'b1;
				val      = acc;
				acc      = 8'h00;
				owned    = 8'h00;
				next_pos = 3'd0;
			end
			return ST_OK;
		endfunction

		// A character seen between tokens: blanks move the position, / and \ open a token.
		function logic [2:0] scan_idle(logic [7:0] c);
			if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
				col_no = sat_up(col_no);
				return ST_OK;
			end
			if (c == CH_LF) begin
				line_no = sat_up(line_no);
				col_no  = 16'd1;
				return ST_OK;
			end
			mark_line = line_no;
			mark_col  = col_no;
			if (c == CH_SLASH || c == CH_BSLASH) begin
				col_no = sat_up(col_no);
				mode   = (c == CH_SLASH) ? SCAN_SLASH : SCAN_BSLASH;
				return ST_OK;
			end
			return ST_TOKEN;
		endfunction

		function void finish_text();
			logic [2:0]  st;
			logic [15:0] ln, cl;
			logic        emit;
			logic [7:0]  val;
			st   = ST_OK;
			ln   = mark_line;
			cl   = mark_col;
			emit = 1'b0;
			val  = 8'h00;
			case (mode)
			SCAN_FAILED: st = fail_st;
			SCAN_SLASH, SCAN_BSLASH, SCAN_HEX_HI, SCAN_HEX_LO, SCAN_HEX_LO_BAD: st = ST_TOKEN;
			SCAN_BITS: st = ST_BITS;
			SCAN_TAIL: st = settle_group(emit, val);
			default: ;
			endcase
			// A clean end with a group still open points at the end of the text.
			if (st == ST_OK && next_pos != 3'd0) begin
				st = ST_INCOMPLETE;
				ln = line_no;
				cl = col_no;
			end
			awaited_outcomes.push_back(make_outcome(emit, val, 1'b1, st, ln, cl));
			restart();
		endfunction

		function void take_char(logic is_end, logic [7:0] c);
			logic [2:0] st;
			logic       emit;
			logic [7:0] val;
			logic [3:0] nib;
			logic       nib_ok;
			st   = ST_OK;
			emit = 1'b0;
			val  = 8'h00;
			if (is_end) begin
				finish_text();
				return;
			end
			case (mode)
			SCAN_FAILED: return;
			SCAN_COMMENT: begin
				if (c == CH_LF) begin
					mode = SCAN_IDLE;
					st   = scan_idle(c);
				end else begin
					col_no = sat_up(col_no);
				end
			end
			SCAN_SLASH: begin
				if (c == CH_SLASH) begin
					col_no = sat_up(col_no);
					mode   = SCAN_COMMENT;
				end else begin
					st = ST_TOKEN;
				end
			end
			SCAN_BSLASH: begin
				if (c == CH_X) begin
					col_no = sat_up(col_no);
					mode   = SCAN_HEX_HI;
				end else if (c == CH_B) begin
					col_no   = sat_up(col_no);
					bit_cnt  = 0;
					tok_mask = 8'h00;
					tok_ones = 8'h00;
					mode     = SCAN_BITS;
				end else begin
					st = ST_TOKEN;
				end
			end
			SCAN_HEX_HI: begin
				// Both digit slots are consumed whatever they hold, a line feed included.
				col_no = sat_up(col_no);
				nib_ok = nibble_of(c, nib);
				if (!nib_ok) begin
					mode = SCAN_HEX_LO_BAD;
				end else begin
					hex_hi = nib;
					mode   = SCAN_HEX_LO;
				end
			end
			SCAN_HEX_LO, SCAN_HEX_LO_BAD: begin
				col_no = sat_up(col_no);
				nib_ok = nibble_of(c, nib);
				if (!nib_ok || mode == SCAN_HEX_LO_BAD) begin
					st = ST_HEX;
				end else if (next_pos != 3'd0) begin
					st = ST_INCOMPLETE;
				end else begin
					emit = 1'b1;
					val  = {hex_hi, nib};
					mode = SCAN_IDLE;
				end
			end
			SCAN_BITS: begin
				if (c == CH_APOS && bit_cnt == 4) begin
					col_no = sat_up(col_no);
				end else if (c == CH_ZERO || c == CH_ONE || c == CH_UNDER) begin
					if (c != CH_UNDER)
						tok_mask[7 - bit_cnt] = 1'b1;
					if (c == CH_ONE)
						tok_ones[7 - bit_cnt] = 1'b1;
					bit_cnt++;
					col_no = sat_up(col_no);
					if (bit_cnt >= 8)
						mode = SCAN_TAIL;
				end else begin
					st = ST_BITS;
				end
			end
			SCAN_TAIL: begin
				// The character after a bit token settles it and is then scanned itself.
				if (c == CH_APOS) begin
					st = ST_BITS;
				end else begin
					st = settle_group(emit, val);
					if (st == ST_OK) begin
						mode = SCAN_IDLE;
						st   = scan_idle(c);
					end
				end
			end
			default: st = scan_idle(c);
			endcase
			if (st != ST_OK) begin
				mode    = SCAN_FAILED;
				fail_st = st;
			end
			if (emit || st != ST_OK)
				awaited_outcomes.push_back(make_outcome(emit, val, 1'b0, st, mark_line,
					mark_col));
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_outcome(decode_outcome_t got);
			decode_outcome_t want;
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatch_count++;
				return;
			end
			want = awaited_outcomes.pop_front();
			compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
			compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
			compare_field("done_res", 16'(want.done), 16'(got.done));
			compare_field("status", 16'(want.status), 16'(got.status));
			compare_field("err_line", want.err_line, got.err_line);
			compare_field("err_col", want.err_col, got.err_col);
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	notation_scoreboard scoreboard;
	bit                 idle_on     = 1'b1;
	int                 sent_items  = 0;
	int                 stall_left  = 0;
	int                 quiet_count = 0;

	byte_text_notation_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// Result side: random stalls of m_tready while idling is allowed.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(4) == 0) begin
			stall_left = $urandom_range(2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every transaction is seen here: results are checked, accepted characters predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				scoreboard.check_outcome({m_tuser, m_tdata[7:0], m_tlast, m_tdata[10:8],
					m_tdata[26:11], m_tdata[42:27]});
			if (s_tvalid && s_tready)
				scoreboard.take_char(s_tuser, s_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_count = 0;
			else
				quiet_count = quiet_count + 1;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_count);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_item(input logic is_end, input logic [7:0] c);
		if (idle_on && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_end;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	task automatic send_char(input logic [7:0] c);
		send_item(1'b0, c);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_end();
		send_item(1'b1, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10)
			return CH_ZERO + 8'(nib);
		return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(nib - 4'd10);
	endfunction

	function automatic logic [7:0] any_but_lf();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		return (c == CH_LF) ? CH_SPACE : c;
	endfunction

	task automatic send_hex(input logic [7:0] v);
		send_char(CH_BSLASH);
		send_char(CH_X);
		send_char(hex_char(v[7:4]));
		send_char(hex_char(v[3:0]));
	endtask

	// One \b token; the apostrophes go after the fourth position.
	task automatic send_bits(input logic [7:0] mask, input logic [7:0] bits, input int apos);
		int i;
		send_char(CH_BSLASH);
		send_char(CH_B);
		for (i = 0; i < 8; i++) begin
			if (i == 4)
				repeat (apos) send_char(CH_APOS);
			send_char(mask[7 - i] ? (bits[7 - i] ? CH_ONE : CH_ZERO) : CH_UNDER);
		end
	endtask

	task automatic send_separator();
		case ($urandom_range(5))
		3: send_char(CH_SPACE);
		4: send_char(CH_LF);
		5: send_char($urandom_range(1) ? CH_TAB : CH_CR);
		default: ;
		endcase
	endtask

	// Contiguous, ordered runs of bit tokens that cover positions from..upto-1 of value.
	task automatic send_runs(input int from, input int upto, input logic [7:0] value);
		int pos, len, i;
		logic [7:0] mask;
		pos = from;
		while (pos < upto) begin
			len = $urandom_range(1, upto - pos);
			for (i = 0; i < 8; i++)
				mask[7 - i] = (i >= pos && i < pos + len);
			send_bits(mask, value, ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0);
			send_separator();
			pos += len;
		end
	endtask

	task automatic send_good_token();
		int i;
		case ($urandom_range(9))
		0: repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(3))
			0: send_char(CH_SPACE);
			1: send_char(CH_TAB);
			2: send_char(CH_CR);
			default: send_char(CH_LF);
			endcase
		end
		1: begin
			send_char(CH_SLASH);
			send_char(CH_SLASH);
			for (i = $urandom_range(6); i > 0; i--)
				send_char(any_but_lf());
			send_char(CH_LF);
		end
		2, 3: send_hex(8'($urandom_range(255)));
		9: begin
			// A token that owns no position leaves the group untouched.
			send_bits(8'h00, 8'($urandom_range(255)), $urandom_range(1));
			send_separator();
		end
		default: send_runs(0, 8, 8'($urandom_range(255)));
		endcase
	endtask

	// A malformed or out-of-place construct; stop asks for the end marker right after it.
	task automatic send_flawed_token(output bit stop);
		int i, k;
		logic [7:0] v;
		stop = 1'b0;
		k    = $urandom_range(1, 7);
		v    = 8'($urandom_range(255));
		case ($urandom_range(11))
		0: send_char(v);
		1: begin
			send_char(CH_SLASH);
			send_char(v);
		end
		2: begin
			send_char(CH_BSLASH);
			send_char(v);
		end
		3: begin
			send_char(CH_BSLASH);
			send_char(CH_X);
			send_char($urandom_range(3) == 0 ? CH_LF : 8'($urandom_range(255)));
			send_char(8'($urandom_range(255)));
		end
		4: begin
			send_char(CH_BSLASH);
			send_char(CH_B);
			for (i = 0; i < 8; i++) begin
				case ($urandom_range(4))
				0: send_char(CH_ZERO);
				1: send_char(CH_ONE);
				2: send_char(CH_UNDER);
				3: send_char(CH_APOS);
				default: send_char(8'($urandom_range(255)));
				endcase
			end
		end
		5: begin
			// Apostrophe right after the eighth position.
			send_bits(8'hFF, v, 0);
			send_char(CH_APOS);
		end
		6: begin
			send_bits(8'($urandom_range(255)), v, 0);
			send_separator();
		end
		7: begin
			// Hex token while a group is still open.
			send_runs(0, k, v);
			send_hex(8'($urandom_range(255)));
		end
		8: begin
			send_runs(0, k, v);
			stop = 1'b1;
		end
		9: begin
			// Token cut short by the end marker.
			send_char($urandom_range(3) == 0 ? CH_SLASH : CH_BSLASH);
			case ($urandom_range(3))
			1: send_char(CH_X);
			2: begin
				send_char(CH_X);
				send_char(hex_char(v[3:0]));
			end
			3: begin
				send_char(CH_B);
				repeat (k) send_char($urandom_range(1) ? CH_ONE : CH_UNDER);
			end
			default: ;
			endcase
			stop = 1'b1;
		end
		10: begin
			send_runs(0, k, v);
			send_bits(8'h80 >> $urandom_range(k - 1), v, 0);
		end
		default: begin
			// Apostrophe anywhere but after the fourth position.
			send_char(CH_BSLASH);
			send_char(CH_B);
			if (k == 4)
				k = 0;
			repeat (k) send_char($urandom_range(1) ? CH_ONE : CH_ZERO);
			send_char(CH_APOS);
		end
		endcase
	endtask

	task automatic send_document(input bit flawed);
		int n_tok, bad_at, i;
		bit stop;
		n_tok  = $urandom_range(1, 10);
		bad_at = flawed ? $urandom_range(n_tok - 1) : -1;
		stop   = 1'b0;
		for (i = 0; i < n_tok && !stop; i++) begin
			if (i == bad_at)
				send_flawed_token(stop);
			else
				send_good_token();
		end
		send_end();
	endtask

	initial begin
		int start;
		scoreboard = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme hex values in mixed case, apostrophes inside a bit token, and an end
		// marker that settles a last run which overlaps the run before it.
		send_text("\\xFf\\x00\\b1010'1___\\b____0000");
		send_end();
		// A lone backslash cut off by the end marker.
		send_char(CH_BSLASH);
		send_end();

		// A run of blanks and then a run of line feeds move the reported token position.
		repeat (LONG_RUN) send_char(CH_SPACE);
		send_char(CH_BSLASH);
		send_char(CH_Q);
		send_end();
		repeat (LONG_RUN) send_char(CH_LF);
		send_text("\\x4");
		send_end();

		start = sent_items;
		while (sent_items - start < RANDOM_ITEMS) begin
			if (sent_items - start > RANDOM_ITEMS - CALM_TAIL)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(3) != 0);
			send_document($urandom_range(9) < 3);
		end
		s_tvalid <= 1'b0;

		while (scoreboard.awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
